// ===== hw/rtl/rgt_pkg.sv =====
`timescale 1ns / 1ps

package rgt_pkg;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } in_item_t;

  typedef struct packed {
    logic [15:0] taper_value;
    logic        inside_support;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH      = 3'd0,
    REG_GRID_HEIGHT     = 3'd1,
    REG_SIN_ANGLE       = 3'd2,
    REG_COS_ANGLE       = 3'd3,
    REG_INV_SIGMA_MAJOR = 3'd4,
    REG_INV_SIGMA_MINOR = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic load_lookup;
    logic load_product;
  } exp_ctl_t;

  localparam int ENTRY_W = 17;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  function automatic logic [63:0] exp_frac_q30(input logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int i = 1; i <= 24; i++) begin
      term = ((term * f) >> 30) / 64'(i);
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [ENTRY_W-1:0] exp_entry(input int k, input int bits);
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] h;
    logic [63:0] e1;
    x  = 64'(k) << (34 - bits);
    n  = x >> 30;
    r  = exp_frac_q30(x & (Q30_ONE - 64'd1));
    h  = exp_frac_q30(Q30_ONE >> 1);
    e1 = (h * h) >> 30;
    for (int j = 0; j < 17; j++) begin
      if (64'(j) < n) r = (r * e1) >> 30;
    end
    return ENTRY_W'((r + 64'd8192) >> 14);
  endfunction

endpackage

// ===== hw/rtl/rgt_exp_interp.sv =====
`timescale 1ns / 1ps

module rgt_exp_interp #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                 clk,
  input  rgt_pkg::exp_ctl_t    ctl,
  input  logic [43:0]          sq0,
  input  logic [43:0]          sq1,
  output logic [15:0]          value
);
  import rgt_pkg::*;

  localparam int N     = 1 << EXP_TABLE_BITS;
  localparam int FB    = 20 - EXP_TABLE_BITS;
  localparam int TAB_W = (N + 1) * ENTRY_W;
  localparam int PW    = ENTRY_W + FB;

  function automatic logic [TAB_W-1:0] build_tab();
    logic [TAB_W-1:0] t;
    t = '0;
    for (int k = 0; k <= N; k++) begin
      t[k*ENTRY_W +: ENTRY_W] = exp_entry(k, EXP_TABLE_BITS);
    end
    return t;
  endfunction

  localparam logic [TAB_W-1:0] TAB = build_tab();

  logic [44:0]               sum;
  logic [27:0]               x;
  logic [EXP_TABLE_BITS:0]   k;
  logic [EXP_TABLE_BITS:0]   k1;
  logic [ENTRY_W-1:0]        ta;
  logic [ENTRY_W-1:0]        tb;

  logic [ENTRY_W-1:0] la;
  logic [ENTRY_W-1:0] ldiff;
  logic [FB-1:0]      lf;
  logic               lzero;

  logic [ENTRY_W-1:0] pa;
  logic [PW-1:0]      prod;
  logic               pzero;

  logic [PW:0]        corr;
  logic [ENTRY_W-1:0] v;

  always_comb begin
    sum = {1'b0, sq0} + {1'b0, sq1};
    x   = 28'((sum + 45'd65536) >> 17);
    k   = {1'b0, x[19:FB]};
    k1  = k + 1'b1;
    ta  = TAB[k*ENTRY_W +: ENTRY_W];
    tb  = TAB[k1*ENTRY_W +: ENTRY_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_lookup) begin
      la    <= ta;
      ldiff <= ta - tb;
      lf    <= x[FB-1:0];
      lzero <= (x[27:20] != 8'd0);
    end
    if (ctl.load_product) begin
      pa    <= la;
      prod  <= PW'(ldiff) * PW'(lf);
      pzero <= lzero;
    end
  end

  always_comb begin
    corr = ({1'b0, prod} + ((PW+1)'(1) << (FB - 1))) >> FB;
    v    = pa - corr[ENTRY_W-1:0];
    if (pzero) value = 16'd0;
    else if (v[ENTRY_W-1]) value = 16'hFFFF;
    else value = v[15:0];
  end

endmodule

// ===== hw/rtl/rotated_gaussian_taper_generator.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall   | in_item_t  {column, row}
// out     | output    | out_valid/out_stall | out_item_t {taper_value, inside_support}
// cfg     | input     | cfg_write           | cfg_index, cfg_data
// One request per cycle while in_stall is low; an output stall that backs up the full pipeline holds the input.
// The depth is set by the chain: offset, square/rotate, abs, split scale multiply,
// combine, square, table lookup, interpolation multiply, output register.
// Synchronous reset clears valid bits and loads register defaults.
// A stall holds the output; empty stages upstream still fill.
module rotated_gaussian_taper_generator #(
  parameter int MAX_DIM        = 4096,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rgt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rgt_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import rgt_pkg::*;

  localparam int DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam logic [12:0] DIM_CAP_V = 13'(DIM_CAP);
  localparam int NS = 8;

  logic [12:0]        grid_width;
  logic [12:0]        grid_height;
  logic signed [15:0] sin_angle;
  logic signed [15:0] cos_angle;
  logic [23:0]        inv_sigma_major;
  logic [23:0]        inv_sigma_minor;

  logic [NS:1] vld;
  logic [NS+1:1] en;
  logic [NS:2] ins;

  logic [12:0]        w_eff;
  logic [12:0]        h_eff;
  logic [12:0]        rad;
  logic signed [14:0] dx_next;
  logic signed [14:0] dy_next;

  logic signed [14:0] dx;
  logic signed [14:0] dy;
  logic [25:0]        rad2;

  logic [26:0]        dsq;
  logic signed [30:0] sdx, cdy, cdx, sdy;

  logic signed [31:0] r0, r1;
  logic [31:0]        a0, a1;
  logic [29:0]        m0, m1;

  logic [41:0]        pl0, ph0, pl1, ph1;
  logic [53:0]        p0, p1;
  logic [34:0]        q0, q1;
  logic [21:0]        u0, u1;
  logic [43:0]        sq0, sq1;

  exp_ctl_t           ectl;
  logic [15:0]        value;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= 13'd256;
      grid_height     <= 13'd256;
      sin_angle       <= 16'sd0;
      cos_angle       <= 16'sd32767;
      inv_sigma_major <= 24'd1048576;
      inv_sigma_minor <= 24'd1048576;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:      grid_width      <= cfg_data[12:0];
        REG_GRID_HEIGHT:     grid_height     <= cfg_data[12:0];
        REG_SIN_ANGLE:       sin_angle       <= cfg_data[15:0];
        REG_COS_ANGLE:       cos_angle       <= cfg_data[15:0];
        REG_INV_SIGMA_MAJOR: inv_sigma_major <= cfg_data;
        REG_INV_SIGMA_MINOR: inv_sigma_minor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NS+1] = !out_valid || !out_stall;
    for (int i = NS; i >= 1; i--) en[i] = !vld[i] || en[i+1];
  end
  assign in_stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
      if (en[NS+1]) out_valid <= vld[NS];
    end
  end

  always_comb begin
    w_eff   = (grid_width > DIM_CAP_V) ? DIM_CAP_V : grid_width;
    h_eff   = (grid_height > DIM_CAP_V) ? DIM_CAP_V : grid_height;
    rad     = {((w_eff < h_eff) ? w_eff[12:1] : h_eff[12:1]), 1'b0};
    dx_next = $signed({2'b00, in_data.column, 1'b0}) - $signed({2'b00, w_eff});
    dy_next = $signed({2'b00, in_data.row, 1'b0}) - $signed({2'b00, h_eff});
  end

  always_comb begin
    dsq = 27'(dx * dx) + 27'(dy * dy);
    r0  = 32'(sdx) - 32'(cdy);
    r1  = 32'(cdx) + 32'(sdy);
    a0  = r0[31] ? 32'(-r0) : 32'(r0);
    a1  = r1[31] ? 32'(-r1) : 32'(r1);
    p0  = 54'(pl0) + (54'(ph0) << 12);
    p1  = 54'(pl1) + (54'(ph1) << 12);
    q0  = 35'((p0 + 54'd524288) >> 20);
    q1  = 35'((p1 + 54'd524288) >> 20);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx   <= dx_next;
      dy   <= dy_next;
      rad2 <= 26'(rad * rad);
    end
    if (en[2]) begin
      ins[2] <= ({1'b0, rad2} >= dsq);
      sdx    <= 31'(sin_angle * dx);
      cdy    <= 31'(cos_angle * dy);
      cdx    <= 31'(cos_angle * dx);
      sdy    <= 31'(sin_angle * dy);
    end
    if (en[3]) begin
      ins[3] <= ins[2];
      m0     <= a0[29:0];
      m1     <= a1[29:0];
    end
    if (en[4]) begin
      ins[4] <= ins[3];
      pl0    <= 42'(m0) * 42'(inv_sigma_major[11:0]);
      ph0    <= 42'(m0) * 42'(inv_sigma_major[23:12]);
      pl1    <= 42'(m1) * 42'(inv_sigma_minor[11:0]);
      ph1    <= 42'(m1) * 42'(inv_sigma_minor[23:12]);
    end
    if (en[5]) begin
      ins[5] <= ins[4];
      u0     <= (q0 > 35'd2097152) ? 22'd2097152 : q0[21:0];
      u1     <= (q1 > 35'd2097152) ? 22'd2097152 : q1[21:0];
    end
    if (en[6]) begin
      ins[6] <= ins[5];
      sq0    <= 44'(u0) * 44'(u0);
      sq1    <= 44'(u1) * 44'(u1);
    end
    if (en[7]) ins[7] <= ins[6];
    if (en[8]) ins[8] <= ins[7];
    if (en[NS+1]) begin
      out_data.inside_support <= ins[NS];
      out_data.taper_value    <= ins[NS] ? value : 16'd0;
    end
  end

  assign ectl.load_lookup  = en[7];
  assign ectl.load_product = en[8];

  rgt_exp_interp #(
    .EXP_TABLE_BITS(EXP_TABLE_BITS)
  ) u_exp (
    .clk   (clk),
    .ctl   (ectl),
    .sq0   (sq0),
    .sq1   (sq1),
    .value (value)
  );

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.inside_support |-> out_data.taper_value == 16'd0)
    else $error("outside point with nonzero taper");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> !in_stall)
    else $error("stall with empty first stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[1])
    else $error("accepted request dropped");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    vld[NS] && en[NS+1] |=> out_valid)
    else $error("last stage lost on advance");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rgt_pkg::*;

  localparam int LATENCY = 9;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAB_BITS = 8;
  localparam int TAB_N = 1 << TAB_BITS;
  localparam int FRAC_BITS = 20 - TAB_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  rotated_gaussian_taper_generator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [12:0] width_q = 13'd256;
  logic [12:0] height_q = 13'd256;
  logic signed [15:0] sine_q = 16'sd0;
  logic signed [15:0] cosine_q = 16'sd32767;
  logic [23:0] major_q = 24'd1048576;
  logic [23:0] minor_q = 24'd1048576;

  logic [63:0] gauss_tab [0:TAB_N];
  out_item_t taper_queue [$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic [63:0] frac_exp(input logic [63:0] f);
    logic [63:0] acc;
    logic [63:0] term;
    acc = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int i = 1; i <= 24; i++) begin
      term = ((term * f) >> 30) / i;
      if (i % 2) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  task automatic fill_gauss_tab();
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] h;
    logic [63:0] e1;
    h = frac_exp(64'd1 << 29);
    e1 = (h * h) >> 30;
    for (int k = 0; k <= TAB_N; k++) begin
      x = 64'(k) << (34 - TAB_BITS);
      n = x >> 30;
      r = frac_exp(x & ((64'd1 << 30) - 1));
      while (n > 0) begin
        r = (r * e1) >> 30;
        n--;
      end
      gauss_tab[k] = (r + 64'd8192) >> 14;
    end
  endtask

  function automatic logic [63:0] scaled_offset(input longint r, input logic [23:0] inv);
    logic [63:0] m;
    logic [63:0] u;
    m = (r < 0) ? 64'(-r) : 64'(r);
    u = (m * 64'(inv) + (64'd1 << 19)) >> 20;
    return (u > (64'd1 << 21)) ? (64'd1 << 21) : u;
  endfunction

  function automatic out_item_t predict_taper(input in_item_t p);
    out_item_t res;
    longint w, h, dx, dy, rad, r0, r1;
    logic [63:0] u0, u1, x, k, f, a, b, v;
    w = width_q > 4096 ? 4096 : width_q;
    h = height_q > 4096 ? 4096 : height_q;
    dx = 2 * longint'(p.column) - w;
    dy = 2 * longint'(p.row) - h;
    rad = 2 * (((w < h) ? w : h) / 2);
    res = '0;
    if (dx * dx + dy * dy > rad * rad) return res;
    r0 = longint'(sine_q) * dx - longint'(cosine_q) * dy;
    r1 = longint'(cosine_q) * dx + longint'(sine_q) * dy;
    u0 = scaled_offset(r0, major_q);
    u1 = scaled_offset(r1, minor_q);
    x = (u0 * u0 + u1 * u1 + (64'd1 << 16)) >> 17;
    if (x >= (64'd1 << 20)) begin
      v = 0;
    end else begin
      k = x >> FRAC_BITS;
      f = x & ((64'd1 << FRAC_BITS) - 1);
      a = gauss_tab[k];
      b = gauss_tab[k + 1];
      v = a - (((a - b) * f + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    end
    if (v > 65535) v = 65535;
    res.taper_value = v[15:0];
    res.inside_support = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (taper_queue.size() == 0) begin
        report_mismatch("unexpected taper", out_data.taper_value, -1);
      end else begin
        want = taper_queue.pop_front();
        if (out_data.taper_value !== want.taper_value)
          report_mismatch("taper_value", out_data.taper_value, want.taper_value);
        if (out_data.inside_support !== want.inside_support)
          report_mismatch("inside_support", out_data.inside_support, want.inside_support);
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_point(input logic [11:0] col, input logic [11:0] row);
    in_item_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    p.column = col;
    p.row = row;
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    taper_queue.push_back(predict_taper(p));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (taper_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [23:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_GRID_WIDTH: width_q = val[12:0];
      REG_GRID_HEIGHT: height_q = val[12:0];
      REG_SIN_ANGLE: sine_q = val[15:0];
      REG_COS_ANGLE: cosine_q = val[15:0];
      REG_INV_SIGMA_MAJOR: major_q = val;
      REG_INV_SIGMA_MINOR: minor_q = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int w, input int h, input int s, input int c,
                              input int ma, input int mi);
    write_reg(REG_GRID_WIDTH, 24'(w));
    write_reg(REG_GRID_HEIGHT, 24'(h));
    write_reg(REG_SIN_ANGLE, 24'(s));
    write_reg(REG_COS_ANGLE, 24'(c));
    write_reg(REG_INV_SIGMA_MAJOR, 24'(ma));
    write_reg(REG_INV_SIGMA_MINOR, 24'(mi));
  endtask

  task automatic test_directed_corners();
    send_point(12'd128, 12'd128);
    send_point(12'd0, 12'd0);
    send_point(12'd4095, 12'd4095);
    send_point(12'd0, 12'd128);
    send_point(12'd128, 12'd0);
    send_point(12'd255, 12'd128);
    send_point(12'd128, 12'd255);
    send_point(12'd129, 12'd140);
    send_point(12'd4095, 12'd0);
    set_geometry(0, 0, 16'h8000, 16'h8000, 24'hFFFFFF, 24'hFFFFFF);
    send_point(12'd0, 12'd0);
    send_point(12'd1, 12'd0);
    set_geometry(8191, 8191, 16'h7FFF, 0, 0, 0);
    send_point(12'd2048, 12'd2048);
    send_point(12'd4095, 12'd2048);
    send_point(12'd0, 12'd2048);
    set_geometry(1, 1, 0, 16'h7FFF, 24'd1048576, 24'd1048576);
    send_point(12'd0, 12'd0);
    send_point(12'd1, 12'd1);
    set_geometry(64, 48, 16'd23170, 16'd23170, 24'd60000, 24'd200000);
    send_point(12'd40, 12'd30);
    send_point(12'd20, 12'd20);
    send_point(12'd32, 12'd24);
    write_reg(reg_index_t'(3'd7), 24'hABCDEF);
    send_point(12'd33, 12'd25);
    send_point(12'd50, 12'd40);
  endtask

  task automatic random_config();
    int w;
    int h;
    w = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 300);
    h = ($urandom_range(3) == 0) ? w : $urandom_range(1, 300);
    set_geometry(w, h, $urandom_range(65535), $urandom_range(65535),
                 ($urandom_range(4) == 0) ? $urandom_range(24'hFFFFFF)
                                          : $urandom_range(1 << 21),
                 ($urandom_range(4) == 0) ? $urandom_range(24'hFFFFFF)
                                          : $urandom_range(1 << 21));
  endtask

  task automatic random_points(input int count);
    int wl;
    int hl;
    for (int i = 0; i < count; i++) begin
      wl = (width_q >= 4096) ? 4095 : width_q;
      hl = (height_q >= 4096) ? 4095 : height_q;
      if ($urandom_range(9) == 0)
        send_point(12'($urandom_range(4095)), 12'($urandom_range(4095)));
      else
        send_point(12'($urandom_range(wl)), 12'($urandom_range(hl)));
    end
  endtask

  task automatic test_random_phases();
    int idle_mix [4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{38, 38}};
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      send_idle_pct = idle_mix[ph % 4][0];
      recv_stall_pct = idle_mix[ph % 4][1];
      random_points(130);
      if (ph == 5) drain();
    end
  endtask

  initial begin
    fill_gauss_tab();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_corners();
    test_random_phases();
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rgt_pkg.sv
hw/rtl/rgt_exp_interp.sv
hw/rtl/rotated_gaussian_taper_generator.sv
tb/sv/tb_top.sv
